// ===== src/ntr_pkg.sv =====
// Shared types, character codes and keyword tables for the numeric token recognizer.
// No dependencies.
package ntr_pkg;

  localparam logic [7:0] CH_DIGIT_LO = 8'd48;
  localparam logic [7:0] CH_DIGIT_HI = 8'd57;
  localparam logic [7:0] CH_E        = 8'd101;
  localparam logic [7:0] CH_MINUS    = 8'd45;
  localparam logic [7:0] CH_PERIOD   = 8'd46;
  localparam logic [7:0] TRUE_LEN    = 8'd4;
  localparam logic [7:0] FALSE_LEN   = 8'd5;
  localparam logic [7:0] POS_MAX     = 8'd255;

  typedef struct packed {
    logic [7:0] token_length;
    logic       num_flag;
    logic       neg_flag;
    logic       dec_flag;
    logic       bool_flag;
  } ntr_result_t;

  // "true"
  function automatic logic [7:0] true_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'd116;
      2'd1:    c = 8'd114;
      2'd2:    c = 8'd117;
      default: c = 8'd101;
    endcase
    return c;
  endfunction

  // "false"
  function automatic logic [7:0] false_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'd102;
      3'd1:    c = 8'd97;
      3'd2:    c = 8'd108;
      3'd3:    c = 8'd115;
      default: c = 8'd101;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    return (v == POS_MAX) ? v : v + 8'd1;
  endfunction

endpackage

// ===== src/ntr_if.sv =====
// Valid/ready channel interfaces for character words and result words.
// No dependencies.
interface ntr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

interface ntr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] token_length;
  logic       num_flag;
  logic       neg_flag;
  logic       dec_flag;
  logic       bool_flag;

  modport source (output valid, output token_length, output num_flag, output neg_flag,
                  output dec_flag, output bool_flag, input ready);
  modport sink   (input valid, input token_length, input num_flag, input neg_flag,
                  input dec_flag, input bool_flag, output ready);
endinterface

// ===== src/ntr_in_reg.sv =====
// Input register stage: captures one character word per cycle while it is empty or its word advances.
// Depends on ntr_pkg.
module ntr_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       up_valid,
  output logic       up_ready,
  input  logic [7:0] up_ch,
  input  logic       up_last,
  input  logic       advance,
  output logic       valid,
  output logic [7:0] ch,
  output logic       last
);
  import ntr_pkg::*;

  logic       valid_r, valid_nxt;
  logic [7:0] ch_r;
  logic       last_r;
  logic       load;

  assign up_ready  = !valid_r || advance;
  assign load      = up_valid && up_ready;
  assign valid_nxt = load ? 1'b1 : (advance ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ch_r   <= up_ch;
      last_r <= up_last;
    end
  end

  assign valid = valid_r;
  assign ch    = ch_r;
  assign last  = last_r;
endmodule

// ===== src/ntr_scan.sv =====
// Scan state of the current token and the result seen at its last character.
// Depends on ntr_pkg.
module ntr_scan (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          ch,
  input  logic                last,
  output ntr_pkg::ntr_result_t result
);
  import ntr_pkg::*;

  logic [7:0] pos_r, pos_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic       numeric_r, numeric_nxt;
  logic       minus_r, minus_nxt;
  logic       expo_r, expo_nxt;
  logic       period_r, period_nxt;
  logic       frac_r, frac_nxt;
  logic       last_e_r, last_e_nxt;
  logic       true_ok_r, true_ok_nxt;
  logic       false_ok_r, false_ok_nxt;
  logic       is_digit;
  logic [7:0] len;

  assign is_digit = (ch >= CH_DIGIT_LO) && (ch <= CH_DIGIT_HI);

  always_comb begin
    pos_nxt      = sat_inc(pos_r);
    cnt_nxt      = cnt_r;
    numeric_nxt  = numeric_r;
    minus_nxt    = minus_r;
    expo_nxt     = expo_r;
    period_nxt   = period_r;
    frac_nxt     = frac_r;
    last_e_nxt   = last_e_r;
    true_ok_nxt  = true_ok_r;
    false_ok_nxt = false_ok_r;

    if (pos_r < TRUE_LEN && ch != true_char(pos_r[1:0])) begin
      true_ok_nxt = 1'b0;
    end
    if (pos_r < FALSE_LEN && ch != false_char(pos_r[2:0])) begin
      false_ok_nxt = 1'b0;
    end

    if (numeric_r) begin
      if (pos_r == 8'd0 && ch == CH_MINUS) begin
        minus_nxt  = 1'b1;
        cnt_nxt    = sat_inc(cnt_r);
        last_e_nxt = 1'b0;
      end else if (pos_r != 8'd0 && ch == CH_E && !expo_r) begin
        expo_nxt   = 1'b1;
        frac_nxt   = 1'b1;
        period_nxt = 1'b0;
        cnt_nxt    = sat_inc(cnt_r);
        last_e_nxt = 1'b1;
      end else if (ch == CH_PERIOD && !period_r) begin
        period_nxt = 1'b1;
        frac_nxt   = 1'b1;
        cnt_nxt    = sat_inc(cnt_r);
        last_e_nxt = 1'b0;
      end else if (is_digit) begin
        cnt_nxt    = sat_inc(cnt_r);
        last_e_nxt = 1'b0;
      end else begin
        numeric_nxt = 1'b0;
      end
    end
  end

  // Result from the state after this character; only used on the last one.
  always_comb begin
    result = '0;
    len    = cnt_nxt;
    if ((minus_nxt && len == 8'd1) || last_e_nxt) begin
      len = 8'd0;
    end
    if (true_ok_nxt && pos_nxt >= TRUE_LEN) begin
      result.token_length = TRUE_LEN;
      result.num_flag     = 1'b1;
      result.bool_flag    = 1'b1;
    end else if (false_ok_nxt && pos_nxt >= FALSE_LEN) begin
      result.token_length = FALSE_LEN;
      result.num_flag     = 1'b1;
      result.bool_flag    = 1'b1;
    end else begin
      result.token_length = len;
      result.num_flag     = (len != 8'd0);
      result.neg_flag     = (len != 8'd0) && minus_nxt;
      result.dec_flag     = (len != 8'd0) && frac_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && last)) begin
      pos_r      <= 8'd0;
      cnt_r      <= 8'd0;
      numeric_r  <= 1'b1;
      minus_r    <= 1'b0;
      expo_r     <= 1'b0;
      period_r   <= 1'b0;
      frac_r     <= 1'b0;
      last_e_r   <= 1'b0;
      true_ok_r  <= 1'b1;
      false_ok_r <= 1'b1;
    end else if (step) begin
      pos_r      <= pos_nxt;
      cnt_r      <= cnt_nxt;
      numeric_r  <= numeric_nxt;
      minus_r    <= minus_nxt;
      expo_r     <= expo_nxt;
      period_r   <= period_nxt;
      frac_r     <= frac_nxt;
      last_e_r   <= last_e_nxt;
      true_ok_r  <= true_ok_nxt;
      false_ok_r <= false_ok_nxt;
    end
  end
endmodule

// ===== src/ntr_out_reg.sv =====
// Result register: holds one result word until the sink takes it.
// Depends on ntr_pkg.
module ntr_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  ntr_pkg::ntr_result_t data,
  output logic                free,
  output logic                valid,
  input  logic                ready,
  output ntr_pkg::ntr_result_t q
);
  import ntr_pkg::*;

  logic        valid_r, valid_nxt;
  ntr_result_t data_r;

  assign free      = !valid_r || ready;
  assign valid_nxt = load ? 1'b1 : (ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data;
    end
  end

  assign valid = valid_r;
  assign q     = data_r;
endmodule

// ===== src/numeric_token_recognizer.sv =====
// Numeric token recognizer: input register, scan logic, result register.
// A token's last character word passes the input register, then the result register, before it is shown at out_chan.
// Throughput: one character word per cycle; a stalled result only holds back a last character.
// The scan state updates directly from the input register; no loop limits the rate.
// Reset (rst_n low, synchronous) empties both registers and restarts the token scan.
// Depends on ntr_pkg, ntr_if, ntr_in_reg, ntr_scan, ntr_out_reg.
module numeric_token_recognizer (
  input  logic      clk,
  input  logic      rst_n,
  ntr_in_if.sink    in_chan,
  ntr_out_if.source out_chan
);
  import ntr_pkg::*;

  logic        s1_valid;
  logic [7:0]  s1_ch;
  logic        s1_last;
  logic        advance;
  logic        out_free;
  ntr_result_t scan_result;
  ntr_result_t out_q;

  // A non-last character never waits on the output side.
  assign advance = s1_valid && (!s1_last || out_free);

  ntr_in_reg u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_chan.valid),
    .up_ready (in_chan.ready),
    .up_ch    (in_chan.ch),
    .up_last  (in_chan.last),
    .advance  (advance),
    .valid    (s1_valid),
    .ch       (s1_ch),
    .last     (s1_last)
  );

  ntr_scan u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .ch     (s1_ch),
    .last   (s1_last),
    .result (scan_result)
  );

  ntr_out_reg u_out (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (advance && s1_last),
    .data  (scan_result),
    .free  (out_free),
    .valid (out_chan.valid),
    .ready (out_chan.ready),
    .q     (out_q)
  );

  assign out_chan.token_length = out_q.token_length;
  assign out_chan.num_flag     = out_q.num_flag;
  assign out_chan.neg_flag     = out_q.neg_flag;
  assign out_chan.dec_flag     = out_q.dec_flag;
  assign out_chan.bool_flag    = out_q.bool_flag;

  a_out_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_chan.valid) |-> $past(s1_valid && s1_last))
    else $error("result appeared without a last character");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && !advance) |=> (s1_valid && $stable(s1_ch) && $stable(s1_last)))
    else $error("held character word lost");

  a_number_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.num_flag == (out_chan.token_length != 8'd0)))
    else $error("number flag disagrees with length");

  a_bool_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.bool_flag) |->
      ((out_chan.token_length == TRUE_LEN || out_chan.token_length == FALSE_LEN)
       && !out_chan.neg_flag && !out_chan.dec_flag))
    else $error("malformed boolean result");
endmodule
